>>> design/number_word_string_lexer_core_assert.svh
// assertion macros used by the lexer front end
`ifndef NUMBER_WORD_STRING_LEXER_CORE_ASSERT_SVH
`define NUMBER_WORD_STRING_LEXER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define NWSL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NWSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/nwsl_pkg.sv
`timescale 1ns / 1ps

package nwsl_pkg;

    localparam int MAX_LEXEME    = 32;
    localparam int POSITION_BITS = 16;

    localparam int IDX_W     = $clog2(MAX_LEXEME);
    localparam int LEN_W     = $clog2(MAX_LEXEME + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
    localparam logic [7:0] CH_LOWER_LO  = 8'h61;
    localparam logic [7:0] CH_LOWER_HI  = 8'h7a;
    localparam logic [7:0] CH_UPPER_LO  = 8'h41;
    localparam logic [7:0] CH_UPPER_HI  = 8'h5a;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOT       = 8'h2e;

    localparam logic [2:0] TK_INT   = 3'd0;
    localparam logic [2:0] TK_WORD  = 3'd1;
    localparam logic [2:0] TK_STR   = 3'd2;
    localparam logic [2:0] TK_FLOAT = 3'd3;
    localparam logic [2:0] TK_ERR   = 3'd4;
    localparam logic [2:0] TK_EOL   = 3'd5;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_INT  = 3'd1,
        MODE_WORD = 3'd2,
        MODE_STR  = 3'd3,
        MODE_DOT  = 3'd4,
        MODE_FRAC = 3'd5,
        MODE_ERR  = 3'd6
    } lex_mode_t;

    typedef enum logic [1:0] {
        OP_FLUSH = 2'd0,
        OP_ERROR = 2'd1,
        OP_EOL   = 2'd2
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SINGLE = 2'd1,
        BK_READ   = 2'd2,
        BK_LOAD   = 2'd3
    } back_state_t;

    // one queued command; single-result commands carry their output fields directly
    typedef struct packed {
        cmd_op_t          op;
        logic [2:0]       tk;
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             trunc;
        logic [7:0]       ch;
        logic [15:0]      pos;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } flush_done_t;

    typedef struct packed {
        lex_mode_t mode;
        logic      append;
        logic      error;
    } start_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= CH_LOWER_LO) && (c <= CH_LOWER_HI)) ||
               ((c >= CH_UPPER_LO) && (c <= CH_UPPER_HI));
    endfunction

    // classification of a character seen from idle
    function automatic start_t start_class(logic [7:0] c);
        start_t r;
        r.mode   = MODE_IDLE;
        r.append = 1'b0;
        r.error  = 1'b0;
        if (is_digit(c))
        begin
            r.mode   = MODE_INT;
            r.append = 1'b1;
        end
        else if (is_letter(c))
        begin
            r.mode   = MODE_WORD;
            r.append = 1'b1;
        end
        else if (c == CH_QUOTE)
        begin
            r.mode = MODE_STR;
        end
        else if (c != CH_SPACE)
        begin
            r.mode  = MODE_ERR;
            r.error = 1'b1;
        end
        return r;
    endfunction

    function automatic cmd_t cmd_flush(logic [2:0] tk, logic bank, logic [LEN_W-1:0] len,
                                       logic trunc);
        cmd_t r;
        r.op    = OP_FLUSH;
        r.tk    = tk;
        r.bank  = bank;
        r.len   = len;
        r.trunc = trunc;
        r.ch    = 8'd0;
        r.pos   = 16'd0;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic cmd_t cmd_error(logic [7:0] ch, logic [15:0] pos);
        cmd_t r;
        r.op    = OP_ERROR;
        r.tk    = TK_ERR;
        r.bank  = 1'b0;
        r.len   = '0;
        r.trunc = 1'b0;
        r.ch    = ch;
        r.pos   = pos;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic cmd_t cmd_eol();
        cmd_t r;
        r.op    = OP_EOL;
        r.tk    = TK_EOL;
        r.bank  = 1'b0;
        r.len   = '0;
        r.trunc = 1'b0;
        r.ch    = 8'd0;
        r.pos   = 16'd0;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

>>> design/number_word_string_lexer_core.sv
// Streaming lexer for integers, words, quoted strings and decimal floats. Each input
// transfer carries one byte or an end-of-line marker; each output transfer carries one
// character of a finished token with its class, length, truncation flag and a last
// mark on the final result caused by that input. Errors report the offending byte and
// its position within the line, then bytes are ignored until end of line. The front
// end accepts one input per cycle while its command queue has room. An input that
// queues two commands stalls the input while the second command is queued. That is
// an end of line that closes a token or raises an error, or a byte that ends a token
// and then fails from idle. The back end takes a command from the queue, then for a
// token does a lexeme memory read and an output load per character; any other result
// is loaded into the output register once its command is taken. The lexeme
// buffer has two banks, so a new token is collected while the previous one is emitted.
// Input stalls while a second command still waits, while the bank to be written is
// still being emitted, or while the queue is full. No clearing pass runs after reset.
`timescale 1ns / 1ps

module number_word_string_lexer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  token_kind,
    output logic [7:0]  lexeme_char,
    output logic [5:0]  lexeme_length,
    output logic [15:0] error_position,
    output logic        truncated,
    output logic        last
);

    // front to queue
    logic                  push_valid;
    nwsl_pkg::cmd_t        push_data;
    logic                  q_full;

    // queue to back
    logic                  q_pop;
    logic                  q_empty;
    nwsl_pkg::cmd_t        pop_data;

    // lexeme writes go forward, bank release comes back
    nwsl_pkg::mem_wr_t     mem_wr;
    nwsl_pkg::flush_done_t done;

    // classifier: runs the mode machine, writes lexeme bytes, queues commands
    nwsl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .character  (character),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_data  (push_data),
        .mem_wr     (mem_wr),
        .done       (done)
    );

    // short command queue decoupling classification from emission
    nwsl_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .pop_data   (pop_data),
        .empty      (q_empty)
    );

    // emitter: expands each command into result transfers through the output register
    nwsl_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_data         (pop_data),
        .mem_wr         (mem_wr),
        .done           (done),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_kind     (token_kind),
        .lexeme_char    (lexeme_char),
        .lexeme_length  (lexeme_length),
        .error_position (error_position),
        .truncated      (truncated),
        .last           (last)
    );

endmodule

>>> design/nwsl_queue.sv
`timescale 1ns / 1ps

module nwsl_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  nwsl_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output nwsl_pkg::cmd_t pop_data,
    output logic           empty
);

    nwsl_pkg::cmd_t                   entry_reg [nwsl_pkg::QUEUE_DEPTH];
    logic [nwsl_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [nwsl_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [nwsl_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    assign full     = (count_reg == nwsl_pkg::QCNT_W'(nwsl_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push_valid && !full;
    assign do_pop   = pop && !empty;

    // pointer wrap written out so the depth need not be a power of two
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == nwsl_pkg::QPTR_W'(nwsl_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + nwsl_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == nwsl_pkg::QPTR_W'(nwsl_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + nwsl_pkg::QPTR_W'(1);
        end
        count_next = count_reg + nwsl_pkg::QCNT_W'(do_push) - nwsl_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/nwsl_front.sv
`timescale 1ns / 1ps
`include "number_word_string_lexer_core_assert.svh"

module nwsl_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [7:0]            character,
    input  logic                  q_full,
    output logic                  push_valid,
    output nwsl_pkg::cmd_t        push_data,
    output nwsl_pkg::mem_wr_t     mem_wr,
    input  nwsl_pkg::flush_done_t done
);

    nwsl_pkg::lex_mode_t                 mode_reg, mode_next;
    logic [nwsl_pkg::LEN_W-1:0]          fill_reg, fill_next;
    logic                                ovf_reg, ovf_next;
    logic [nwsl_pkg::POSITION_BITS-1:0]  pos_reg, pos_next;
    logic                                bank_reg, bank_next;
    logic [1:0]                          busy_reg, busy_next;
    logic                                pend_valid_reg, pend_valid_next;
    nwsl_pkg::cmd_t                      pend_reg;

    nwsl_pkg::cmd_t                      c0, c1, fl;
    logic                                c0_v, c1_v;
    logic [2:0]                          flush_tk;
    nwsl_pkg::start_t                    idle;
    logic                                restart, from_idle, flush_set;
    logic                                app, wr_ok, app_bank;
    logic [nwsl_pkg::LEN_W-1:0]          app_base;
    logic [15:0]                         cur_pos;
    logic                                accept, busy_set;

    assign idle    = nwsl_pkg::start_class(character);
    assign cur_pos = 16'(pos_reg);

    always_comb
    begin
        unique case (mode_reg)
            nwsl_pkg::MODE_WORD: flush_tk = nwsl_pkg::TK_WORD;
            nwsl_pkg::MODE_STR:  flush_tk = nwsl_pkg::TK_STR;
            nwsl_pkg::MODE_FRAC: flush_tk = nwsl_pkg::TK_FLOAT;
            default:             flush_tk = nwsl_pkg::TK_INT;
        endcase
        fl = nwsl_pkg::cmd_flush(flush_tk, bank_reg, fill_reg, ovf_reg);
    end

    // classification of one character against the current mode
    always_comb
    begin
        mode_next = mode_reg;
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        pos_next  = kind ? '0 : pos_reg + nwsl_pkg::POSITION_BITS'(1);
        c0        = nwsl_pkg::cmd_eol();
        c1        = nwsl_pkg::cmd_eol();
        c0_v      = 1'b0;
        c1_v      = 1'b0;
        restart   = 1'b0;
        from_idle = 1'b0;
        flush_set = 1'b0;
        app       = 1'b0;
        app_bank  = bank_reg;
        app_base  = fill_reg;

        if (kind)
        begin
            unique case (mode_reg)
                nwsl_pkg::MODE_INT, nwsl_pkg::MODE_WORD, nwsl_pkg::MODE_FRAC:
                begin
                    c0        = fl;
                    c0_v      = 1'b1;
                    c1_v      = 1'b1;
                    flush_set = 1'b1;
                end
                nwsl_pkg::MODE_STR, nwsl_pkg::MODE_DOT:
                begin
                    c0   = nwsl_pkg::cmd_error(8'd0, cur_pos);
                    c0_v = 1'b1;
                    c1_v = 1'b1;
                end
                default:
                begin
                    c0_v = 1'b1;
                end
            endcase
            mode_next = nwsl_pkg::MODE_IDLE;
            fill_next = '0;
            ovf_next  = 1'b0;
            bank_next = flush_set ? ~bank_reg : bank_reg;
        end
        else
        begin
            unique case (mode_reg)
                nwsl_pkg::MODE_INT:
                begin
                    if (nwsl_pkg::is_digit(character))
                    begin
                        app = 1'b1;
                    end
                    else if (character == nwsl_pkg::CH_DOT)
                    begin
                        app       = 1'b1;
                        mode_next = nwsl_pkg::MODE_DOT;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                nwsl_pkg::MODE_WORD:
                begin
                    if (nwsl_pkg::is_letter(character))
                        app = 1'b1;
                    else
                        restart = 1'b1;
                end
                nwsl_pkg::MODE_STR:
                begin
                    if (character == nwsl_pkg::CH_QUOTE)
                    begin
                        c0        = fl;
                        c0_v      = 1'b1;
                        flush_set = 1'b1;
                        mode_next = nwsl_pkg::MODE_IDLE;
                        fill_next = '0;
                        ovf_next  = 1'b0;
                        bank_next = ~bank_reg;
                    end
                    else
                    begin
                        app = 1'b1;
                    end
                end
                nwsl_pkg::MODE_DOT:
                begin
                    if (nwsl_pkg::is_digit(character))
                    begin
                        app       = 1'b1;
                        mode_next = nwsl_pkg::MODE_FRAC;
                    end
                    else
                    begin
                        c0        = nwsl_pkg::cmd_error(character, cur_pos);
                        c0_v      = 1'b1;
                        mode_next = nwsl_pkg::MODE_ERR;
                        fill_next = '0;
                        ovf_next  = 1'b0;
                    end
                end
                nwsl_pkg::MODE_FRAC:
                begin
                    if (nwsl_pkg::is_digit(character))
                        app = 1'b1;
                    else
                        restart = 1'b1;
                end
                nwsl_pkg::MODE_ERR:
                begin
                end
                default:
                begin
                    from_idle = 1'b1;
                end
            endcase

            // token ended: emit it, then look at the character again from idle
            if (restart)
            begin
                c0        = fl;
                c0_v      = 1'b1;
                flush_set = 1'b1;
                bank_next = ~bank_reg;
                fill_next = '0;
                ovf_next  = 1'b0;
                app_bank  = ~bank_reg;
                app_base  = '0;
                mode_next = idle.mode;
                app       = idle.append;
                if (idle.error)
                begin
                    c1   = nwsl_pkg::cmd_error(character, cur_pos);
                    c1_v = 1'b1;
                end
            end

            if (from_idle)
            begin
                mode_next = idle.mode;
                app       = idle.append;
                fill_next = '0;
                ovf_next  = 1'b0;
                app_base  = '0;
                if (idle.error)
                begin
                    c0   = nwsl_pkg::cmd_error(character, cur_pos);
                    c0_v = 1'b1;
                end
            end
        end

        // drop characters past the buffer and remember it
        wr_ok = app && (app_base < nwsl_pkg::LEN_W'(nwsl_pkg::MAX_LEXEME));
        if (app)
        begin
            if (wr_ok)
                fill_next = app_base + nwsl_pkg::LEN_W'(1);
            else
                ovf_next = 1'b1;
        end

        if (c1_v)
            c1.last = 1'b1;
        else
            c0.last = 1'b1;
    end

    // stall while a second command waits, the queue is full, or the bank is being read
    assign in_ready = !pend_valid_reg && !q_full && !(wr_ok && busy_reg[app_bank]);
    assign accept   = in_valid && in_ready;
    assign busy_set = accept && flush_set && (fill_reg != '0);

    assign mem_wr.valid = accept && wr_ok;
    assign mem_wr.addr  = {app_bank, app_base[nwsl_pkg::IDX_W-1:0]};
    assign mem_wr.data  = character;

    assign push_valid = pend_valid_reg ? !q_full : (accept && c0_v);
    assign push_data  = pend_valid_reg ? pend_reg : c0;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (pend_valid_reg && !q_full)
            pend_valid_next = 1'b0;
        if (accept && c1_v)
            pend_valid_next = 1'b1;
        for (int b = 0; b < 2; b++)
        begin
            busy_next[b] = (busy_reg[b] && !(done.valid && (done.bank == 1'(b)))) ||
                           (busy_set && (bank_reg == 1'(b)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= nwsl_pkg::MODE_IDLE;
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            pos_reg        <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                fill_reg <= fill_next;
                ovf_reg  <= ovf_next;
                pos_reg  <= pos_next;
                bank_reg <= bank_next;
            end
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && c1_v)
            pend_reg <= c1;
    end

    `NWSL_ASSERT_SAME(a_no_write_busy_bank, mem_wr.valid, !busy_reg[mem_wr.addr[nwsl_pkg::ADDR_W-1]], "lexeme write into a bank still being emitted")
    `NWSL_ASSERT_SAME(a_done_matches_busy, done.valid, busy_reg[done.bank], "flush done for a bank that was not busy")
    `NWSL_ASSERT_SAME(a_no_push_when_full, push_valid, !q_full, "command pushed into a full queue")
    `NWSL_ASSERT_NEXT(a_pending_drains, pend_valid_reg && !q_full, !pend_valid_reg, "pending command not drained")

endmodule

>>> design/nwsl_back.sv
`timescale 1ns / 1ps

module nwsl_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  nwsl_pkg::cmd_t        q_data,
    input  nwsl_pkg::mem_wr_t     mem_wr,
    output nwsl_pkg::flush_done_t done,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            token_kind,
    output logic [7:0]            lexeme_char,
    output logic [5:0]            lexeme_length,
    output logic [15:0]           error_position,
    output logic                  truncated,
    output logic                  last
);

    logic [7:0]                     mem [nwsl_pkg::MEM_DEPTH];
    logic [7:0]                     rd_data_reg;
    logic                           rd_en;
    logic [nwsl_pkg::ADDR_W-1:0]    rd_addr;

    nwsl_pkg::back_state_t          state_reg, state_next;
    nwsl_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [nwsl_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                           final_char, out_free, load;

    logic                           out_valid_reg, out_valid_next;
    logic [2:0]                     token_kind_reg, token_kind_next;
    logic [7:0]                     lexeme_char_reg, lexeme_char_next;
    logic [5:0]                     lexeme_length_reg, lexeme_length_next;
    logic [15:0]                    error_position_reg, error_position_next;
    logic                           truncated_reg, truncated_next;
    logic                           last_reg, last_next;

    assign rd_addr    = {cmd_reg.bank, idx_reg};
    assign final_char = (nwsl_pkg::LEN_W'(idx_reg) + nwsl_pkg::LEN_W'(1)) == cmd_reg.len;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next          = state_reg;
        cmd_next            = cmd_reg;
        idx_next            = idx_reg;
        q_pop               = 1'b0;
        rd_en               = 1'b0;
        load                = 1'b0;
        done.valid          = 1'b0;
        done.bank           = cmd_reg.bank;
        token_kind_next     = cmd_reg.tk;
        lexeme_char_next    = cmd_reg.ch;
        lexeme_length_next  = 6'(cmd_reg.len);
        error_position_next = cmd_reg.pos;
        truncated_next      = cmd_reg.trunc;
        last_next           = cmd_reg.last;

        unique case (state_reg)
            nwsl_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    idx_next = '0;
                    if ((q_data.op == nwsl_pkg::OP_FLUSH) && (q_data.len != '0))
                        state_next = nwsl_pkg::BK_READ;
                    else
                        state_next = nwsl_pkg::BK_SINGLE;
                end
            end
            nwsl_pkg::BK_SINGLE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = nwsl_pkg::BK_IDLE;
                end
            end
            nwsl_pkg::BK_READ:
            begin
                rd_en      = 1'b1;
                state_next = nwsl_pkg::BK_LOAD;
            end
            nwsl_pkg::BK_LOAD:
            begin
                if (out_free)
                begin
                    load             = 1'b1;
                    lexeme_char_next = rd_data_reg;
                    last_next        = cmd_reg.last && final_char;
                    if (final_char)
                    begin
                        done.valid = 1'b1;
                        state_next = nwsl_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + nwsl_pkg::IDX_W'(1);
                        state_next = nwsl_pkg::BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = nwsl_pkg::BK_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nwsl_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        if (load)
        begin
            token_kind_reg     <= token_kind_next;
            lexeme_char_reg    <= lexeme_char_next;
            lexeme_length_reg  <= lexeme_length_next;
            error_position_reg <= error_position_next;
            truncated_reg      <= truncated_next;
            last_reg           <= last_next;
        end
    end

    // lexeme buffer, two banks
    always_ff @(posedge clk)
    begin
        if (mem_wr.valid)
            mem[mem_wr.addr] <= mem_wr.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid      = out_valid_reg;
    assign token_kind     = token_kind_reg;
    assign lexeme_char    = lexeme_char_reg;
    assign lexeme_length  = lexeme_length_reg;
    assign error_position = error_position_reg;
    assign truncated      = truncated_reg;
    assign last           = last_reg;

endmodule

>>> verif/tb_number_word_string_lexer_core.sv
`timescale 1ns / 1ps

module tb_number_word_string_lexer_core;

    import nwsl_pkg::*;

    // input kinds carried on the kind port
    localparam bit KIND_CHAR = 1'b0;
    localparam bit KIND_EOL  = 1'b1;

    // run length limits
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int PRINT_CAP    = 40;

    // one input transfer waiting in the stimulus queue
    typedef struct {
        bit         k;
        logic [7:0] ch;
        int         gap;
    } lex_input_t;

    // one output transfer as the lexer should present it
    typedef struct {
        logic [2:0]  tk;
        logic [7:0]  ch;
        logic [5:0]  len;
        logic [15:0] pos;
        logic        trunc;
        logic        last;
    } token_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [7:0]  character = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  token_kind;
    logic [7:0]  lexeme_char;
    logic [5:0]  lexeme_length;
    logic [15:0] error_position;
    logic        truncated;
    logic        last;

    number_word_string_lexer_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .character      (character),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_kind     (token_kind),
        .lexeme_char    (lexeme_char),
        .lexeme_length  (lexeme_length),
        .error_position (error_position),
        .truncated      (truncated),
        .last           (last)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // lexer prediction: mirrors the token state machine one transfer at a time
    // ------------------------------------------------------------------
    lex_mode_t   lx_mode = MODE_IDLE;
    logic [7:0]  lx_chars [MAX_LEXEME];
    int          lx_fill = 0;
    bit          lx_over = 1'b0;
    logic [15:0] lx_pos = 16'd0;

    token_char_t step_chars[$];       // results of the transfer being predicted
    token_char_t expected_chars[$];   // results still owed by the lexer
    lex_input_t  pending_inputs[$];   // stimulus not yet presented

    int mismatch_count = 0;
    int made_items = 0;
    bit calm = 1'b0;                  // no input gaps while set

    function automatic bit digit_char(logic [7:0] c);
        return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
    endfunction

    function automatic bit alpha_char(logic [7:0] c);
        return (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
               (c >= CH_UPPER_LO && c <= CH_UPPER_HI);
    endfunction

    function automatic void add_result(logic [2:0] tk, logic [7:0] ch, int len,
                                       logic [15:0] pos, bit trunc);
        token_char_t r;
        r.tk    = tk;
        r.ch    = ch;
        r.len   = 6'(len);
        r.pos   = pos;
        r.trunc = trunc;
        r.last  = 1'b0;
        step_chars.push_back(r);
    endfunction

    // characters past the buffer are dropped but mark the token as truncated
    function automatic void keep_char(logic [7:0] c);
        if (lx_fill < MAX_LEXEME)
        begin
            lx_chars[lx_fill] = c;
            lx_fill++;
        end
        else
            lx_over = 1'b1;
    endfunction

    // one result per stored character; an empty string still gives one result
    function automatic void emit_token(logic [2:0] tk);
        if (lx_fill == 0)
            add_result(tk, 8'd0, 0, 16'd0, lx_over);
        for (int i = 0; i < lx_fill; i++)
            add_result(tk, lx_chars[i], lx_fill, 16'd0, lx_over);
        lx_fill = 0;
        lx_over = 1'b0;
        lx_mode = MODE_IDLE;
    endfunction

    function automatic void emit_error(logic [7:0] c, logic [15:0] p);
        lx_fill = 0;
        lx_over = 1'b0;
        lx_mode = MODE_ERR;
        add_result(TK_ERR, c, 0, p, 1'b0);
    endfunction

    function automatic void open_token(logic [7:0] c, logic [15:0] p);
        if (digit_char(c))
        begin
            lx_mode = MODE_INT;
            keep_char(c);
        end
        else if (alpha_char(c))
        begin
            lx_mode = MODE_WORD;
            keep_char(c);
        end
        else if (c == CH_QUOTE)
            lx_mode = MODE_STR;
        else if (c != CH_SPACE)
            emit_error(c, p);
    endfunction

    function automatic void predict_lexer(bit k, logic [7:0] c);
        logic [15:0] p;
        p = lx_pos;
        step_chars.delete();
        if (k == KIND_EOL)
        begin
            // open tokens close at end of line; a string or bare dot is an error
            case (lx_mode)
                MODE_INT:  emit_token(TK_INT);
                MODE_WORD: emit_token(TK_WORD);
                MODE_FRAC: emit_token(TK_FLOAT);
                MODE_STR,
                MODE_DOT:  emit_error(8'd0, p);
                default:   ;
            endcase
            lx_fill = 0;
            lx_over = 1'b0;
            lx_mode = MODE_IDLE;
            lx_pos  = 16'd0;
            add_result(TK_EOL, 8'd0, 0, 16'd0, 1'b0);
        end
        else
        begin
            lx_pos = lx_pos + 16'd1;
            case (lx_mode)
                MODE_INT:
                    if (digit_char(c))
                        keep_char(c);
                    else if (c == CH_DOT)
                    begin
                        keep_char(c);
                        lx_mode = MODE_DOT;
                    end
                    else
                    begin
                        emit_token(TK_INT);
                        open_token(c, p);
                    end
                MODE_WORD:
                    if (alpha_char(c))
                        keep_char(c);
                    else
                    begin
                        emit_token(TK_WORD);
                        open_token(c, p);
                    end
                MODE_STR:
                    if (c == CH_QUOTE)
                        emit_token(TK_STR);
                    else
                        keep_char(c);
                MODE_DOT:
                    if (digit_char(c))
                    begin
                        keep_char(c);
                        lx_mode = MODE_FRAC;
                    end
                    else
                        emit_error(c, p);
                MODE_FRAC:
                    if (digit_char(c))
                        keep_char(c);
                    else
                    begin
                        emit_token(TK_FLOAT);
                        open_token(c, p);
                    end
                MODE_ERR:
                    ;   // bytes are dropped until end of line
                default:
                begin
                    lx_mode = MODE_IDLE;
                    open_token(c, p);
                end
            endcase
        end
        if (step_chars.size() > 0)
            step_chars[step_chars.size() - 1].last = 1'b1;
        foreach (step_chars[i])
            expected_chars.push_back(step_chars[i]);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // sampling at the rising edge: predict on input transfers, check output ones
    // ------------------------------------------------------------------
    bit in_took = 1'b0;
    bit out_took = 1'b0;

    always @(posedge clk)
    begin : watch_ports
        token_char_t want;
        in_took  <= rst_n && in_valid && in_ready;
        out_took <= rst_n && out_valid && out_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_lexer(kind, character);
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d char %02h",
                                              token_kind, lexeme_char));
                else
                begin
                    want = expected_chars.pop_front();
                    if (token_kind !== want.tk)
                        report_mismatch($sformatf("token_kind %0d, want %0d",
                                                  token_kind, want.tk));
                    if (lexeme_char !== want.ch)
                        report_mismatch($sformatf("lexeme_char %02h, want %02h",
                                                  lexeme_char, want.ch));
                    if (lexeme_length !== want.len)
                        report_mismatch($sformatf("lexeme_length %0d, want %0d",
                                                  lexeme_length, want.len));
                    if (error_position !== want.pos)
                        report_mismatch($sformatf("error_position %0d, want %0d",
                                                  error_position, want.pos));
                    if (truncated !== want.trunc)
                        report_mismatch($sformatf("truncated %0b, want %0b",
                                                  truncated, want.trunc));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input driver: each item waits out its own gap, then holds until transfer
    // ------------------------------------------------------------------
    int in_wait = -1;

    always @(negedge clk)
    begin : feed_input
        lex_input_t item;
        bit         show;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_took))
        begin
            show = 1'b0;
            if (pending_inputs.size() > 0)
            begin
                if (in_wait < 0)
                    in_wait = pending_inputs[0].gap;
                if (in_wait == 0)
                begin
                    item = pending_inputs.pop_front();
                    kind      <= item.k;
                    character <= item.ch;
                    show      = 1'b1;
                    in_wait   = -1;
                end
                else
                    in_wait--;
            end
            in_valid <= show;
        end
    end

    // ------------------------------------------------------------------
    // output sink: a fresh stall per result, with calm stretches now and then
    // ------------------------------------------------------------------
    int out_stall = -1;
    bit out_calm = 1'b0;

    always @(negedge clk)
    begin : drain_output
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_took || out_stall < 0)
            begin
                if ($urandom_range(0, 29) == 0)
                    out_calm = !out_calm;
                out_stall = out_calm ? 0 : $urandom_range(0, 6);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic push_item(input bit k, input logic [7:0] c);
        lex_input_t item;
        item.k   = k;
        item.ch  = c;
        item.gap = calm ? 0 : $urandom_range(0, 6);
        pending_inputs.push_back(item);
        made_items++;
    endtask

    task automatic push_char(input logic [7:0] c);
        push_item(KIND_CHAR, c);
    endtask

    task automatic push_eol();
        push_item(KIND_EOL, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // mostly short lexemes, now and then one near or past the buffer
    function automatic int pick_length(int shortest);
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(MAX_LEXEME - 4, MAX_LEXEME + 8);
        return $urandom_range(shortest, 6);
    endfunction

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
            push_char(8'($urandom_range(CH_DIGIT_LO, CH_DIGIT_HI)));
    endtask

    task automatic push_letters(input int n);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 1))
                push_char(8'($urandom_range(CH_LOWER_LO, CH_LOWER_HI)));
            else
                push_char(8'($urandom_range(CH_UPPER_LO, CH_UPPER_HI)));
    endtask

    // string body: any byte but the closing quote
    task automatic push_string_body(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = 8'($urandom_range(0, 255));
            while (c == CH_QUOTE)
                c = 8'($urandom_range(0, 255));
            push_char(c);
        end
    endtask

    task automatic push_random_token();
        logic [7:0] c;
        int         sel;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            push_digits(pick_length(1));
        else if (sel < 40)
            push_letters(pick_length(1));
        else if (sel < 55)
        begin
            push_char(CH_QUOTE);
            push_string_body(pick_length(0));
            push_char(CH_QUOTE);
        end
        else if (sel < 70)
        begin
            push_digits($urandom_range(1, 4));
            push_char(CH_DOT);
            push_digits(pick_length(1));
        end
        else if (sel < 78)
        begin
            // broken forms: bad fraction, unterminated string, bare dot at end of line
            case ($urandom_range(0, 2))
                0:
                begin
                    push_digits($urandom_range(1, 3));
                    push_char(CH_DOT);
                    c = 8'($urandom_range(0, 255));
                    while (digit_char(c))
                        c = 8'($urandom_range(0, 255));
                    push_char(c);
                end
                1:
                begin
                    push_char(CH_QUOTE);
                    push_string_body($urandom_range(0, 5));
                end
                default:
                begin
                    push_digits($urandom_range(1, 3));
                    push_char(CH_DOT);
                end
            endcase
            push_eol();
        end
        else if (sel < 86)
        begin
            // any byte at all, usually closed off so the line recovers
            push_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 7)
                push_eol();
        end
        else
            push_eol();
        // separator between tokens, or none so the next byte ends the token
        if ($urandom_range(0, 1))
            push_char(CH_SPACE);
    endtask

    // ------------------------------------------------------------------
    // reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int target;

        // directed: one of each token class and a range of ways a token or line ends
        push_text("42 ab");
        push_eol();                 // integer ended by space, word ended by end of line
        push_text("\"\"3.14\"q");
        push_eol();                 // empty string, float ended by quote, open string at end of line
        push_text("x9.5");
        push_eol();                 // word ended by digit, float closed by end of line
        push_char(8'h00);
        push_char(8'hff);
        push_eol();                 // error on lowest byte, highest byte dropped in error mode
        push_text("5.x");
        push_eol();                 // non-digit after the decimal point
        push_text("9.");
        push_eol();                 // end of line right after the decimal point
        push_eol();                 // end of line from idle

        // random token streams
        target = made_items + RANDOM_ITEMS;
        while (made_items < target)
        begin
            if ($urandom_range(0, 9) == 0)
                calm = !calm;
            push_random_token();
        end
        push_eol();

        // run of spaces: the error lands well into the line
        calm = 1'b1;
        for (int i = 0; i < 40; i++)
            push_char(CH_SPACE);
        push_text("7!");
        push_text("ab");            // dropped in error mode
        push_eol();
        calm = 1'b0;
        push_text("1 a");
        push_eol();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_inputs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_number_word_string_lexer_core OK");
        else
            $display("tb_number_word_string_lexer_core NOT OK");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin : watchdog
        #4_000_000;
        $display("tb_number_word_string_lexer_core NOT OK");
        $finish;
    end

endmodule
